/* hdl/gang_pkg.sv */
// ----------------------------------------------------------------------------
// gang_pkg: shared definitions of the grid axis neighbor generator
// Field widths, register map codes and the result item type used by the
// register block, the classify stage, the emitter and the top level.
// ----------------------------------------------------------------------------
package gang_pkg;

   // Field widths fixed by the interface.
   localparam int PT_W        = 24;
   localparam int EXT_W       = 13;
   localparam int DIM_W       = 3;
   localparam int AXIS_W      = 2;
   localparam int EXTENT_REGS = 4;

   // Configuration port geometry.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;

   // Register indexes (byte address is four times the index).
   localparam logic [REG_IDX_W-1:0] REG_DIM_COUNT = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_EXTENT_0  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_EXTENT_1  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_EXTENT_2  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_EXTENT_3  = 3'd4;

   // Reset values of the shape registers.
   localparam logic [DIM_W-1:0] DIM_RESET = 3'd0;
   localparam logic [EXT_W-1:0] EXT_RESET = 13'd1;

   // One result item as it leaves the block.
   typedef struct packed {
      logic [PT_W-1:0]   nbr_index;
      logic [AXIS_W-1:0] axis;
      logic              direction;
      logic              found;
      logic              last;
   } rsp_item_type;

endpackage

/* hdl/gang_csr.sv */
// ----------------------------------------------------------------------------
// gang_csr: shape registers and stride sequencer
// Holds dim_count and the extents behind an APB-style port. After reset and
// after every write it recomputes the per-axis strides with one saturating
// multiply per cycle and holds busy high while doing so.
// ----------------------------------------------------------------------------
module gang_csr #(
   parameter int AXES     = 4,
   parameter int CAP_BITS = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [gang_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [gang_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [gang_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output logic                           busy,
   output logic [CAP_BITS:0]              lane_stride [AXES],
   output logic [CAP_BITS:0]              lane_mod [AXES],
   output logic [CAP_BITS:0]              total,
   output logic [AXES-1:0]                lane_used
);
   import gang_pkg::*;

   localparam int MW     = CAP_BITS + 1;
   localparam int PW     = MW + EXT_W;
   localparam int STEP_W = (AXES > 1) ? $clog2(AXES) : 1;
   localparam logic [MW-1:0] CAP = MW'(1) << CAP_BITS;

   logic [DIM_W-1:0]     dim_count_ff;
   logic [EXT_W-1:0]     extent_ff [EXTENT_REGS];
   logic                 busy_ff;
   logic [STEP_W-1:0]    step_ff;
   logic [MW-1:0]        mod_ff [AXES];
   logic                 wr_en;
   logic [REG_IDX_W-1:0] reg_idx;
   logic [DIM_W-1:0]     axes_n;
   logic [MW-1:0]        base_val;
   logic [EXT_W-1:0]     ext_val;
   logic [PW-1:0]        prod;
   logic [MW-1:0]        prod_sat;

   // A write lands in the access cycle; the port never waits.
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];

   // Register writes; out-of-map indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_count_ff <= DIM_RESET;
         for (int i = 0; i < EXTENT_REGS; i++) begin
            extent_ff[i] <= EXT_RESET;
         end
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_DIM_COUNT: dim_count_ff <= csr_pwdata[DIM_W-1:0];
            REG_EXTENT_0:  extent_ff[0] <= csr_pwdata[EXT_W-1:0];
            REG_EXTENT_1:  extent_ff[1] <= csr_pwdata[EXT_W-1:0];
            REG_EXTENT_2:  extent_ff[2] <= csr_pwdata[EXT_W-1:0];
            REG_EXTENT_3:  extent_ff[3] <= csr_pwdata[EXT_W-1:0];
            default: ;
         endcase
      end
   end

   // Register reads.
   always_comb begin
      unique case (reg_idx)
         REG_DIM_COUNT: csr_prdata = CSR_DATA_W'(dim_count_ff);
         REG_EXTENT_0:  csr_prdata = CSR_DATA_W'(extent_ff[0]);
         REG_EXTENT_1:  csr_prdata = CSR_DATA_W'(extent_ff[1]);
         REG_EXTENT_2:  csr_prdata = CSR_DATA_W'(extent_ff[2]);
         REG_EXTENT_3:  csr_prdata = CSR_DATA_W'(extent_ff[3]);
         default:       csr_prdata = '0;
      endcase
   end

   // The lower stride of axis d is the product of the extents below it.
   assign lane_stride[0] = MW'(1);
   for (genvar d = 1; d < AXES; d++) begin : g_stride
      assign lane_stride[d] = mod_ff[d-1];
   end
   for (genvar d = 0; d < AXES; d++) begin : g_mod
      assign lane_mod[d] = mod_ff[d];
   end

   // One multiply per cycle, saturated so that large grids stay exact in effect.
   always_comb begin
      base_val = lane_stride[0];
      ext_val  = extent_ff[0];
      for (int d = 0; d < AXES; d++) begin
         if (step_ff == STEP_W'(d)) begin
            base_val = lane_stride[d];
            ext_val  = extent_ff[d];
         end
      end
      prod     = PW'(base_val) * PW'(ext_val);
      prod_sat = (prod > PW'(CAP)) ? CAP : prod[MW-1:0];
   end

   // Sequencer control: restart on reset and on every write.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (wr_en) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (busy_ff) begin
         if (step_ff == STEP_W'(AXES - 1)) begin
            busy_ff <= 1'b0;
         end else begin
            step_ff <= step_ff + STEP_W'(1);
         end
      end
   end

   // Stride storage.
   always_ff @(posedge clock) begin
      if (busy_ff && !wr_en) begin
         mod_ff[step_ff] <= prod_sat;
      end
   end

   assign busy = busy_ff;

   // Axes in use, limited to the lanes that exist.
   assign axes_n = (dim_count_ff > DIM_W'(AXES)) ? DIM_W'(AXES) : dim_count_ff;

   // Point count of the grid and the lanes in use.
   always_comb begin
      total = MW'(1);
      for (int d = 0; d < AXES; d++) begin
         if (axes_n == DIM_W'(d + 1)) begin
            total = mod_ff[d];
         end
         lane_used[d] = (axes_n > DIM_W'(d));
      end
   end

endmodule

/* hdl/gang_rem_pipe.sv */
// ----------------------------------------------------------------------------
// gang_rem_pipe: pipelined remainder unit
// For every axis lane it reduces the point index modulo that lane's upper
// stride by restoring division, two quotient bits per stage.
// ----------------------------------------------------------------------------
module gang_rem_pipe #(
   parameter int AXES     = 4,
   parameter int CAP_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  logic [gang_pkg::PT_W-1:0] in_point,
   input  logic [CAP_BITS:0]        lane_mod [AXES],
   output logic                     out_valid,
   output logic [gang_pkg::PT_W-1:0] out_point,
   output logic [gang_pkg::PT_W-1:0] out_rem [AXES]
);
   import gang_pkg::*;

   localparam int MW     = CAP_BITS + 1;
   localparam int STEPS  = 2;
   localparam int NSTAGE = (PT_W + STEPS - 1) / STEPS;

   logic [NSTAGE-1:0] valid_ff;
   logic [PT_W-1:0]   point_ff [NSTAGE];
   logic [PT_W-1:0]   rem_ff [NSTAGE][AXES];
   logic [PT_W-1:0]   rem_in [NSTAGE][AXES];

   // Restoring steps of one stage: subtract the modulus shifted by k where it fits.
   function automatic logic [PT_W-1:0] rem_steps(input logic [PT_W-1:0] rem,
                                                 input logic [MW-1:0] modulus,
                                                 input int stage);
      logic [PT_W-1:0] r;
      int k;
      r = rem;
      for (int j = 0; j < STEPS; j++) begin
         k = PT_W - 1 - (stage * STEPS + j);
         if (k >= 0) begin
            if ((MW'(r) >> k) >= modulus) begin
               r = r - (PT_W'(modulus) << k);
            end
         end
      end
      return r;
   endfunction

   // Next remainders of all stages and lanes.
   always_comb begin
      for (int l = 0; l < AXES; l++) begin
         rem_in[0][l] = rem_steps(in_point, lane_mod[l], 0);
      end
      for (int s = 1; s < NSTAGE; s++) begin
         for (int l = 0; l < AXES; l++) begin
            rem_in[s][l] = rem_steps(rem_ff[s-1][l], lane_mod[l], s);
         end
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < NSTAGE; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         point_ff[0] <= in_point;
         for (int s = 1; s < NSTAGE; s++) begin
            point_ff[s] <= point_ff[s-1];
         end
         for (int s = 0; s < NSTAGE; s++) begin
            for (int l = 0; l < AXES; l++) begin
               rem_ff[s][l] <= rem_in[s][l];
            end
         end
      end
   end

   assign out_valid = valid_ff[NSTAGE-1];
   assign out_point = point_ff[NSTAGE-1];
   for (genvar l = 0; l < AXES; l++) begin : g_out
      assign out_rem[l] = rem_ff[NSTAGE-1][l];
   end

endmodule

/* hdl/gang_classify.sv */
// ----------------------------------------------------------------------------
// gang_classify: neighbor classification stage
// From each lane's remainder it decides whether the minus and plus neighbors
// lie inside the grid and below the index limit, and forms their indexes.
// ----------------------------------------------------------------------------
module gang_classify #(
   parameter int AXES       = 4,
   parameter int CAP_BITS   = 24,
   parameter int INDEX_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  logic [gang_pkg::PT_W-1:0] in_point,
   input  logic [gang_pkg::PT_W-1:0] in_rem [AXES],
   input  logic [CAP_BITS:0]        lane_stride [AXES],
   input  logic [CAP_BITS:0]        lane_mod [AXES],
   input  logic [CAP_BITS:0]        total,
   input  logic [AXES-1:0]          lane_used,
   output logic                     out_valid,
   output logic [2*AXES-1:0]        out_mask,
   output logic [gang_pkg::PT_W-1:0] out_nbr [2*AXES]
);
   import gang_pkg::*;

   localparam int MW = CAP_BITS + 1;
   localparam int VW = CAP_BITS + 2;

   logic                valid_ff;
   logic [2*AXES-1:0]   mask_ff;
   logic [PT_W-1:0]     nbr_ff [2*AXES];
   logic [2*AXES-1:0]   mask_in;
   logic [PT_W-1:0]     nbr_in [2*AXES];
   logic                in_range;
   logic [VW-1:0]       v_minus [AXES];
   logic [VW-1:0]       v_plus [AXES];

   assign in_range = (MW'(in_point) < total);

   // Per lane: coordinate above zero, coordinate below extent minus one, index fit.
   always_comb begin
      for (int d = 0; d < AXES; d++) begin
         v_minus[d]       = VW'(in_point) - VW'(lane_stride[d]);
         v_plus[d]        = VW'(in_point) + VW'(lane_stride[d]);
         mask_in[2*d]     = lane_used[d] && in_range
                            && (MW'(in_rem[d]) >= lane_stride[d])
                            && (v_minus[d][VW-1:INDEX_BITS] == '0);
         mask_in[2*d + 1] = lane_used[d] && in_range
                            && ((VW'(in_rem[d]) + VW'(lane_stride[d])) < VW'(lane_mod[d]))
                            && (v_plus[d][VW-1:INDEX_BITS] == '0);
         nbr_in[2*d]      = v_minus[d][PT_W-1:0];
         nbr_in[2*d + 1]  = v_plus[d][PT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mask_ff <= mask_in;
         for (int i = 0; i < 2*AXES; i++) begin
            nbr_ff[i] <= nbr_in[i];
         end
      end
   end

   assign out_valid = valid_ff;
   assign out_mask  = mask_ff;
   for (genvar i = 0; i < 2*AXES; i++) begin : g_out
      assign out_nbr[i] = nbr_ff[i];
   end

endmodule

/* hdl/gang_emit.sv */
// ----------------------------------------------------------------------------
// gang_emit: result serializer
// Holds one classified point and sends its neighbors, lowest axis first and
// minus before plus, one per cycle while the registered result stage has room.
// A point without neighbors gives a single result with found cleared.
// ----------------------------------------------------------------------------
module gang_emit #(
   parameter int AXES = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [2*AXES-1:0]             in_mask,
   input  logic [gang_pkg::PT_W-1:0]      in_nbr [2*AXES],
   output logic                          in_take,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output gang_pkg::rsp_item_type        rsp_item
);
   import gang_pkg::*;

   localparam int CW = $clog2(2*AXES);

   logic              cur_valid_ff;
   logic [2*AXES-1:0] cur_mask_ff;
   logic [PT_W-1:0]   cur_nbr_ff [2*AXES];
   logic              out_valid_ff;
   rsp_item_type      out_item_ff;
   logic              out_free;
   logic              emit;
   logic              done;
   logic [CW-1:0]     pick;
   logic [2*AXES-1:0] rest;
   rsp_item_type      item;

   // Lowest pending neighbor and what remains after it.
   always_comb begin
      pick = '0;
      for (int i = 2*AXES - 1; i >= 0; i--) begin
         if (cur_mask_ff[i]) begin
            pick = CW'(i);
         end
      end
   end
   assign rest = cur_mask_ff & (cur_mask_ff - 1'b1);

   // Transfer control.
   assign out_free = !out_valid_ff || rsp_ready;
   assign emit     = cur_valid_ff && out_free;
   assign done     = emit && (rest == '0);
   assign in_take  = !cur_valid_ff || done;

   // Result fields; all but last are zero when there is no neighbor, and last is then set.
   always_comb begin
      item.found     = |cur_mask_ff;
      item.last      = (rest == '0);
      item.nbr_index = item.found ? cur_nbr_ff[pick] : '0;
      item.axis      = item.found ? AXIS_W'(pick >> 1) : '0;
      item.direction = item.found ? pick[0] : 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_take) begin
            cur_valid_ff <= in_valid;
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         cur_mask_ff <= in_mask;
         for (int i = 0; i < 2*AXES; i++) begin
            cur_nbr_ff[i] <= in_nbr[i];
         end
      end else if (emit) begin
         cur_mask_ff <= rest;
      end
      if (emit) begin
         out_item_ff <= item;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

/* hdl/grid_axis_neighbor_generator.sv */
// ----------------------------------------------------------------------------
// grid_axis_neighbor_generator: face neighbors of a point in an N-d grid
// Splits a linear row-major point index into per-axis remainders in a
// pipelined remainder unit, classifies each axis' two neighbors and sends
// those that lie in the grid, or a single not-found result, one per transfer.
//
//   Channel  Direction  Handshake                     Payload
//   req_     in         req_valid / req_ready         pt_index
//   rsp_     out        rsp_valid / rsp_ready         nbr_index, axis,
//                                                     direction, found, last
//   csr_     in         psel, penable, pwrite, pready dim_count, extent_0..3
//
// A point is taken only while the pipeline advances and no stride update runs;
// it occupies the emitter for one result per neighbor (one when there is none).
// A point passes 12 remainder stages, one classify stage and two emitter stages.
// After reset and after every register write the stride sequencer runs with
// req_ready low. A stall on the result side holds every stage in place;
// nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module grid_axis_neighbor_generator #(
   parameter int MAX_DIMS   = 4,
   parameter int INDEX_BITS = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [gang_pkg::PT_W-1:0]        req_pt_index,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [gang_pkg::PT_W-1:0]        rsp_nbr_index,
   output logic [gang_pkg::AXIS_W-1:0]      rsp_axis,
   output logic                            rsp_direction,
   output logic                            rsp_found,
   output logic                            rsp_last,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [gang_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [gang_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [gang_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import gang_pkg::*;

   localparam int AXES     = (MAX_DIMS < EXTENT_REGS) ? MAX_DIMS : EXTENT_REGS;
   localparam int CAP_BITS = (INDEX_BITS > PT_W) ? INDEX_BITS : PT_W;

   logic               busy;
   logic [CAP_BITS:0]  lane_stride [AXES];
   logic [CAP_BITS:0]  lane_mod [AXES];
   logic [CAP_BITS:0]  total;
   logic [AXES-1:0]    lane_used;
   logic               advance;
   logic               rem_valid;
   logic [PT_W-1:0]    rem_point;
   logic [PT_W-1:0]    rem_val [AXES];
   logic               cls_valid;
   logic [2*AXES-1:0]  cls_mask;
   logic [PT_W-1:0]    cls_nbr [2*AXES];
   logic               emit_take;
   rsp_item_type       rsp_item;

   // Registers and stride sequencer.
   gang_csr #(
      .AXES     (AXES),
      .CAP_BITS (CAP_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .busy        (busy),
      .lane_stride (lane_stride),
      .lane_mod    (lane_mod),
      .total       (total),
      .lane_used   (lane_used)
   );

   // The pipeline moves whenever its last stage is empty or handed over.
   assign advance   = !cls_valid || emit_take;
   assign req_ready = advance && !busy;

   gang_rem_pipe #(
      .AXES     (AXES),
      .CAP_BITS (CAP_BITS)
   ) u_rem_pipe (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid && !busy),
      .in_point  (req_pt_index),
      .lane_mod  (lane_mod),
      .out_valid (rem_valid),
      .out_point (rem_point),
      .out_rem   (rem_val)
   );

   gang_classify #(
      .AXES       (AXES),
      .CAP_BITS   (CAP_BITS),
      .INDEX_BITS (INDEX_BITS)
   ) u_classify (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (rem_valid),
      .in_point    (rem_point),
      .in_rem      (rem_val),
      .lane_stride (lane_stride),
      .lane_mod    (lane_mod),
      .total       (total),
      .lane_used   (lane_used),
      .out_valid   (cls_valid),
      .out_mask    (cls_mask),
      .out_nbr     (cls_nbr)
   );

   gang_emit #(
      .AXES (AXES)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cls_valid),
      .in_mask   (cls_mask),
      .in_nbr    (cls_nbr),
      .in_take   (emit_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // Result fields onto their ports.
   assign rsp_nbr_index = rsp_item.nbr_index;
   assign rsp_axis      = rsp_item.axis;
   assign rsp_direction = rsp_item.direction;
   assign rsp_found     = rsp_item.found;
   assign rsp_last      = rsp_item.last;

endmodule
